[rtl/deq_pkg.sv]
// ----------------------------------------------------------------------------
// deq_pkg
// Shared types, operation and status codes for the double-ended queue.
// ----------------------------------------------------------------------------
package deq_pkg;

   localparam int DEFAULT_DEPTH = 8;
   localparam int DATA_W        = 32;
   localparam int OP_W          = 2;
   localparam int STATUS_W      = 2;
   localparam int FILL_W        = 4;

   // operation codes
   localparam logic [OP_W-1:0] OP_PUSH_FRONT = 2'd0;
   localparam logic [OP_W-1:0] OP_POP_FRONT  = 2'd1;
   localparam logic [OP_W-1:0] OP_PUSH_REAR  = 2'd2;
   localparam logic [OP_W-1:0] OP_POP_REAR   = 2'd3;

   // status codes
   localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

   typedef struct packed {
      logic [OP_W-1:0]          op;
      logic signed [DATA_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] data_out;
      logic [STATUS_W-1:0]      status;
      logic                     is_full;
      logic                     is_empty;
      logic [FILL_W-1:0]        fill_count;
   } rsp_type;

   // memory port strobes from the pointer logic
   typedef struct packed {
      logic wr_en;
      logic rd_en;
   } mem_ctl_type;

   // per-item result fields known at accept time
   typedef struct packed {
      logic                pop_ok;
      logic [STATUS_W-1:0] status;
      logic                is_full;
      logic                is_empty;
      logic [FILL_W-1:0]   fill_count;
   } meta_type;

endpackage

[rtl/deq_store.sv]
// ----------------------------------------------------------------------------
// deq_store
// Slot memory: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module deq_store #(
   parameter int DEPTH = deq_pkg::DEFAULT_DEPTH,
   parameter int IW    = $clog2(DEPTH)
) (
   input  logic                             clock,
   input  deq_pkg::mem_ctl_type             mem_ctl,
   input  logic [IW-1:0]                    addr,
   input  logic signed [deq_pkg::DATA_W-1:0] wr_data,
   output logic signed [deq_pkg::DATA_W-1:0] rd_data
);

   logic signed [deq_pkg::DATA_W-1:0] mem [DEPTH];
   logic signed [deq_pkg::DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_ctl.wr_en) begin
         mem[addr] <= wr_data;
      end
   end

   // hold the read word until the next read
   always_ff @(posedge clock) begin
      if (mem_ctl.rd_en) begin
         rd_data_ff <= mem[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/deq_ctrl.sv]
// ----------------------------------------------------------------------------
// deq_ctrl
// Head, tail and count registers; decode the operation into a memory access.
// ----------------------------------------------------------------------------
module deq_ctrl #(
   parameter int DEPTH = deq_pkg::DEFAULT_DEPTH,
   parameter int IW    = $clog2(DEPTH),
   parameter int CW    = $clog2(DEPTH + 1)
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_fire,
   input  deq_pkg::req_type     req_item,
   output deq_pkg::mem_ctl_type mem_ctl,
   output logic [IW-1:0]        addr,
   output deq_pkg::meta_type    meta
);

   localparam logic [IW-1:0] LAST_IDX = IW'(DEPTH - 1);
   localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

   logic [IW-1:0] head_ff, head_in;
   logic [IW-1:0] tail_ff, tail_in;
   logic [CW-1:0] count_ff, count_in;
   logic          full;
   logic          empty;
   logic [IW-1:0] head_next, head_prev, tail_next, tail_prev;

   assign full  = (count_ff == FULL_CNT);
   assign empty = (count_ff == '0);

   assign head_next = (head_ff == LAST_IDX) ? '0 : head_ff + IW'(1);
   assign head_prev = (head_ff == '0) ? LAST_IDX : head_ff - IW'(1);
   assign tail_next = (tail_ff == LAST_IDX) ? '0 : tail_ff + IW'(1);
   assign tail_prev = (tail_ff == '0) ? LAST_IDX : tail_ff - IW'(1);

   always_comb begin
      head_in       = head_ff;
      tail_in       = tail_ff;
      count_in      = count_ff;
      mem_ctl       = '0;
      addr          = head_ff;
      meta          = '0;
      meta.status   = deq_pkg::ST_DONE;
      unique case (req_item.op)
         deq_pkg::OP_PUSH_FRONT: begin
            addr = head_prev;
            if (full) begin
               meta.status = deq_pkg::ST_FULL;
            end else begin
               head_in       = head_prev;
               count_in      = count_ff + CW'(1);
               mem_ctl.wr_en = req_fire;
            end
         end
         deq_pkg::OP_POP_FRONT: begin
            addr = head_ff;
            if (empty) begin
               meta.status = deq_pkg::ST_EMPTY;
            end else begin
               head_in       = head_next;
               count_in      = count_ff - CW'(1);
               mem_ctl.rd_en = req_fire;
               meta.pop_ok   = 1'b1;
            end
         end
         deq_pkg::OP_PUSH_REAR: begin
            addr = tail_ff;
            if (full) begin
               meta.status = deq_pkg::ST_FULL;
            end else begin
               tail_in       = tail_next;
               count_in      = count_ff + CW'(1);
               mem_ctl.wr_en = req_fire;
            end
         end
         deq_pkg::OP_POP_REAR: begin
            addr = tail_prev;
            if (empty) begin
               meta.status = deq_pkg::ST_EMPTY;
            end else begin
               tail_in       = tail_prev;
               count_in      = count_ff - CW'(1);
               mem_ctl.rd_en = req_fire;
               meta.pop_ok   = 1'b1;
            end
         end
         default: begin
            meta.status = deq_pkg::ST_DONE;
         end
      endcase
      meta.is_full    = (count_in == FULL_CNT);
      meta.is_empty   = (count_in == '0);
      meta.fill_count = deq_pkg::FILL_W'(count_in);
   end

   // advance pointers only on an accepted item
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else if (req_fire) begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_CNT)
      else $error("word count exceeds depth");

   a_full_reject: assert property (@(posedge clock) disable iff (reset)
      req_fire && meta.status == deq_pkg::ST_FULL |=> $stable(count_ff))
      else $error("rejected push changed the count");

   a_one_access: assert property (@(posedge clock) disable iff (reset)
      !(mem_ctl.wr_en && mem_ctl.rd_en))
      else $error("read and write issued together");

endmodule

[rtl/double_ended_queue.sv]
// ----------------------------------------------------------------------------
// double_ended_queue
// Circular double-ended queue of signed 32-bit words held in a slot memory.
// ----------------------------------------------------------------------------
// Usage:
//   req channel carries one item: an op (push front, pop front, push rear,
//   pop rear) and a value used by pushes. rsp channel returns one item per
//   request: the popped word (zero for pushes and rejected pops), a status
//   (done, full, empty) and the full/empty flags and fill count after the op.
//   The result is registered: it appears in the cycle after the request is
//   accepted, with the pop word from the slot memory's registered read port.
//   Throughput: one item per cycle while the result side keeps taking them.
//   Stall: a result waits in the output stage while rsp_ready is low; the
//   pop word stays in the memory read register and no new request is taken
//   until the waiting result leaves (req_ready = no result held or it is
//   being taken this cycle).
//   Reset: head, tail and count go to zero and the output stage empties.
//   Slot contents are not cleared; pops only read slots that pushes wrote.
//   DEPTH sets the capacity (2 to 1024); fill_count reports the low 4 bits.
// ----------------------------------------------------------------------------
module double_ended_queue #(
   parameter int DEPTH = deq_pkg::DEFAULT_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  deq_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output deq_pkg::rsp_type rsp_data
);

   localparam int IW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   logic                              req_fire;
   deq_pkg::mem_ctl_type              mem_ctl;
   logic [IW-1:0]                     addr;
   deq_pkg::meta_type                 meta;
   logic signed [deq_pkg::DATA_W-1:0] rd_data;

   logic              rsp_valid_ff, rsp_valid_in;
   deq_pkg::meta_type meta_ff;

   // take a new item when the output stage is free or draining
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;

   deq_ctrl #(
      .DEPTH (DEPTH),
      .IW    (IW),
      .CW    (CW)
   ) u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_fire (req_fire),
      .req_item (req_data),
      .mem_ctl  (mem_ctl),
      .addr     (addr),
      .meta     (meta)
   );

   deq_store #(
      .DEPTH (DEPTH),
      .IW    (IW)
   ) u_store (
      .clock   (clock),
      .mem_ctl (mem_ctl),
      .addr    (addr),
      .wr_data (req_data.value),
      .rd_data (rd_data)
   );

   // output stage: hold until taken, reload on each accepted item
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         meta_ff <= meta;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_data.data_out   = meta_ff.pop_ok ? rd_data : '0;
   assign rsp_data.status     = meta_ff.status;
   assign rsp_data.is_full    = meta_ff.is_full;
   assign rsp_data.is_empty   = meta_ff.is_empty;
   assign rsp_data.fill_count = meta_ff.fill_count;

   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> rsp_valid)
      else $error("accepted item produced no result");

   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data.is_full && rsp_data.is_empty))
      else $error("queue reported full and empty together");

   a_reject_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != deq_pkg::ST_DONE |-> rsp_data.data_out == '0)
      else $error("rejected operation returned nonzero data");

endmodule

[dv/tb_double_ended_queue.sv]
// ----------------------------------------------------------------------------
// tb_double_ended_queue
// Self-checking bench for the circular double-ended queue: a cycle-free
// predictor tracks slots, front/back pointers and fill level, and every
// result item is compared field by field against the predicted one.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_double_ended_queue;

   localparam int DEPTH      = deq_pkg::DEFAULT_DEPTH;
   localparam int CLK_PERIOD = 10;

   // DUT ports, all inputs start at known values
   logic             clock     = 1'b0;
   logic             reset     = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   deq_pkg::req_type req_data  = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   deq_pkg::rsp_type rsp_data;

   // traffic shaping, in percent of cycles
   int send_idle_pct = 0;
   int rsp_stall_pct = 0;

   // predictor state: slot contents, front slot, slot past the back, fill level
   logic signed [deq_pkg::DATA_W-1:0] slot_mem [DEPTH];
   int front_slot  = 0;
   int back_slot   = 0;
   int held_words  = 0;

   // predicted result items, oldest first
   deq_pkg::rsp_type expected_deq_rsp [$];

   // run statistics
   int error_count   = 0;
   int checked_count = 0;
   int push_count    = 0;
   int pop_count     = 0;
   int full_rejects  = 0;
   int empty_rejects = 0;

   double_ended_queue #(.DEPTH(DEPTH)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // Hard stop in case the block hangs.
   initial begin
      #(2_000_000);
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // Print one line per mismatch and count it.
   task automatic report_mismatch(string msg);
      $display("ERROR @%0t: %s", $time, msg);
      error_count++;
   endtask

   task automatic check_field(string field, logic [31:0] got, logic [31:0] want);
      if (got !== want) begin
         report_mismatch($sformatf("%s got 0x%0h, expected 0x%0h", field, got, want));
      end
   endtask

   // Apply one operation to the predicted deque and return the result item.
   // Full and empty are judged by the fill level only; pointers wrap both ways.
   function automatic deq_pkg::rsp_type predict_deque_op(deq_pkg::req_type item);
      deq_pkg::rsp_type res;
      res        = '0;
      res.status = deq_pkg::ST_DONE;
      case (item.op) inside
         deq_pkg::OP_PUSH_FRONT, deq_pkg::OP_PUSH_REAR: begin
            if (held_words == DEPTH) begin
               // reject: state untouched, data stays zero
               res.status = deq_pkg::ST_FULL;
               full_rejects++;
            end else if (item.op == deq_pkg::OP_PUSH_FRONT) begin
               front_slot           = (front_slot + DEPTH - 1) % DEPTH;
               slot_mem[front_slot] = item.value;
               held_words++;
               push_count++;
            end else begin
               slot_mem[back_slot] = item.value;
               back_slot           = (back_slot + 1) % DEPTH;
               held_words++;
               push_count++;
            end
         end
         default: begin
            if (held_words == 0) begin
               res.status = deq_pkg::ST_EMPTY;
               empty_rejects++;
            end else if (item.op == deq_pkg::OP_POP_FRONT) begin
               res.data_out = slot_mem[front_slot];
               front_slot   = (front_slot + 1) % DEPTH;
               held_words--;
               pop_count++;
            end else begin
               back_slot    = (back_slot + DEPTH - 1) % DEPTH;
               res.data_out = slot_mem[back_slot];
               held_words--;
               pop_count++;
            end
         end
      endcase
      res.is_full    = (held_words == DEPTH);
      res.is_empty   = (held_words == 0);
      res.fill_count = deq_pkg::FILL_W'(held_words);
      return res;
   endfunction

   // Send one item. Drop valid only for an idle gap, so a back-to-back item
   // keeps valid high with a single assignment in that time step.
   task automatic send_item(logic [deq_pkg::OP_W-1:0]          op,
                            logic signed [deq_pkg::DATA_W-1:0] value);
      deq_pkg::req_type item;
      item.op    = op;
      item.value = value;
      if ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < send_idle_pct);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      // valid is high at every edge from here on; wait for the one where
      // ready is high too, then predict at that accept edge
      do @(posedge clock); while (req_ready !== 1'b1);
      expected_deq_rsp.push_back(predict_deque_op(item));
   endtask

   // Result side: randomly stall, one assignment per edge.
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
   end

   // Check every accepted result item against the oldest prediction.
   always @(posedge clock) begin
      deq_pkg::rsp_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_ready) begin
         if (expected_deq_rsp.size() == 0) begin
            report_mismatch($sformatf("unexpected result item 0x%0h", rsp_data));
         end else begin
            want = expected_deq_rsp.pop_front();
            check_field("data_out", rsp_data.data_out, want.data_out);
            check_field("status", rsp_data.status, want.status);
            check_field("is_full", rsp_data.is_full, want.is_full);
            check_field("is_empty", rsp_data.is_empty, want.is_empty);
            check_field("fill_count", rsp_data.fill_count, want.fill_count);
            checked_count++;
         end
      end
   end

   // Mostly full-range random words, with the extremes mixed in.
   function automatic logic signed [deq_pkg::DATA_W-1:0] random_word();
      case ($urandom_range(0, 15))
         0: begin
            return 32'sh7FFF_FFFF;
         end
         1: begin
            return 32'sh8000_0000;
         end
         2: begin
            return '0;
         end
         3: begin
            return -1;
         end
         default: begin
            return $urandom;
         end
      endcase
   endfunction

   // Both pops on a fresh, empty deque must be rejected.
   task automatic test_empty_pops();
      send_item(deq_pkg::OP_POP_FRONT, 32'sh1234_5678);
      send_item(deq_pkg::OP_POP_REAR, -1);
   endtask

   // Fill to capacity from both ends with extreme and alternating-bit words;
   // front pushes wrap the front pointer below slot zero.
   task automatic test_extreme_pushes();
      send_item(deq_pkg::OP_PUSH_REAR, 32'sh7FFF_FFFF);
      send_item(deq_pkg::OP_PUSH_REAR, 32'sh8000_0000);
      send_item(deq_pkg::OP_PUSH_REAR, 32'sh0000_0000);
      send_item(deq_pkg::OP_PUSH_REAR, -1);
      send_item(deq_pkg::OP_PUSH_FRONT, 32'sh5555_5555);
      send_item(deq_pkg::OP_PUSH_FRONT, 32'shAAAA_AAAA);
      send_item(deq_pkg::OP_PUSH_FRONT, 1);
      send_item(deq_pkg::OP_PUSH_FRONT, -2);
   endtask

   // Pushes into a full deque are rejected at either end.
   task automatic test_full_rejects();
      send_item(deq_pkg::OP_PUSH_FRONT, 32'sh0F0F_0F0F);
      send_item(deq_pkg::OP_PUSH_REAR, 32'shF0F0_F0F0);
   endtask

   // Drain half from each end, then pop once more at each end on the now empty
   // deque, whose pointers are back at slot zero.
   task automatic test_drain_both_ends();
      repeat (DEPTH / 2) send_item(deq_pkg::OP_POP_FRONT, 32'sh7FFF_FFFF);
      repeat (DEPTH / 2) send_item(deq_pkg::OP_POP_REAR, 32'sh8000_0000);
      send_item(deq_pkg::OP_POP_REAR, 0);
      send_item(deq_pkg::OP_POP_FRONT, 0);
   endtask

   // Random traffic in bursts that lean toward pushing, popping or neither,
   // so the fill level swings between empty and full many times.
   task automatic test_random_traffic(int items, int idle_pct, int stall_pct);
      int                       push_bias;
      logic [deq_pkg::OP_W-1:0] op;
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      push_bias     = 50;
      for (int i = 0; i < items; i++) begin
         if (i % 16 == 0) begin
            case ($urandom_range(0, 2))
               0:       push_bias = 15;
               1:       push_bias = 50;
               default: push_bias = 85;
            endcase
         end
         if ($urandom_range(0, 99) < push_bias) begin
            op = $urandom_range(0, 1) ? deq_pkg::OP_PUSH_REAR : deq_pkg::OP_PUSH_FRONT;
         end else begin
            op = $urandom_range(0, 1) ? deq_pkg::OP_POP_REAR : deq_pkg::OP_POP_FRONT;
         end
         send_item(op, random_word());
      end
   endtask

   initial begin
      foreach (slot_mem[i]) slot_mem[i] = '0;

      // hold reset at start, then release
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      test_empty_pops();
      test_extreme_pushes();
      test_full_rejects();
      test_drain_both_ends();

      // no idling, slow sender, slow receiver, light idling on both sides
      test_random_traffic(100, 0, 0);
      test_random_traffic(100, 75, 0);
      test_random_traffic(100, 0, 75);
      test_random_traffic(100, 10, 10);

      // stop sending, let outstanding results drain, then wait on a little
      // longer so a stray result item would still be caught
      req_valid <= 1'b0;
      while (expected_deq_rsp.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);

      $display("Checked %0d result items: %0d pushes and %0d pops done,",
               checked_count, push_count, pop_count);
      $display("  %0d pushes turned away when full, %0d pops turned away when empty.",
               full_rejects, empty_rejects);
      if (error_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
